// File: rtl/swsn_pkg.sv
// Shared types and constants for the sliding window sender.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package swsn_pkg;

	// command codes
	localparam logic [1:0] CMD_SEND    = 2'd0;
	localparam logic [1:0] CMD_ACK     = 2'd1;
	localparam logic [1:0] CMD_NAK     = 2'd2;
	localparam logic [1:0] CMD_TIMEOUT = 2'd3;

	// descriptor queue and window
	localparam int QUEUE_DEPTH  = 16;
	localparam int WIN_W        = 4;
	localparam int WINDOW_RESET = 4;
	localparam int WINDOW_MAX   = 8;

	// at most this many frames are resent for one nak
	localparam int NAK_MAX = 8;
	localparam int NAK_W   = $clog2(NAK_MAX + 1);

	// command queue between front and back
	localparam int OPQ_DEPTH = 2;
	localparam int OPQ_PW    = $clog2(OPQ_DEPTH);
	localparam int OPQ_CW    = $clog2(OPQ_DEPTH + 1);

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] frame_sequence;
		logic [31:0] ack_number;
		logic [15:0] frame_tag;
		logic [6:0]  frame_length;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] tx_tag;
		logic [31:0] tx_sequence;
		logic [6:0]  tx_length;
		logic        last_of_run;
	} out_beat_t;

	// classified command: key is the send sequence or the ack/nak number
	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] key;
		logic [15:0] tag;
		logic [6:0]  len;
	} op_t;

	// one frame descriptor as held in the queue memory
	typedef struct packed {
		logic [31:0] seq;
		logic [15:0] tag;
		logic [6:0]  len;
	} desc_t;

endpackage

// File: rtl/swsn_front.sv
// Front end: accepts input beats and classifies them into queue commands.
// Depends on swsn_pkg.
module swsn_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  swsn_pkg::in_beat_t in_beat,
	output logic               op_valid,
	output swsn_pkg::op_t      op,
	input  logic               op_full
);

	logic          valid_s1;
	swsn_pkg::op_t op_s1;
	logic          accept;
	logic          push;

	// pick the key the back end compares against and drop unused fields
	function automatic swsn_pkg::op_t classify(input swsn_pkg::in_beat_t b);
		swsn_pkg::op_t o;
		o.cmd = b.command;
		if (b.command == swsn_pkg::CMD_SEND) begin
			o.key = b.frame_sequence;
			o.tag = b.frame_tag;
			o.len = b.frame_length;
		end else begin
			o.key = b.ack_number;
			o.tag = '0;
			o.len = '0;
		end
		return o;
	endfunction

	assign push     = valid_s1 && !op_full;
	assign in_stall = valid_s1 && op_full;
	assign accept   = in_valid && !in_stall;
	assign op_valid = valid_s1;
	assign op       = op_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= classify(in_beat);
		end
	end

endmodule

// File: rtl/swsn_opq.sv
// Short command queue that decouples the front end from the back end.
// Depends on swsn_pkg.
module swsn_opq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  swsn_pkg::op_t push_op,
	output logic          full,
	output logic          valid,
	output swsn_pkg::op_t head_op,
	input  logic          pop
);

	swsn_pkg::op_t                  entry_q [swsn_pkg::OPQ_DEPTH];
	logic [swsn_pkg::OPQ_PW-1:0]    wr_ptr_q;
	logic [swsn_pkg::OPQ_PW-1:0]    rd_ptr_q;
	logic [swsn_pkg::OPQ_CW-1:0]    fill_q;
	logic                           do_push;
	logic                           do_pop;

	function automatic logic [swsn_pkg::OPQ_PW-1:0] next_ptr(
		input logic [swsn_pkg::OPQ_PW-1:0] p);
		if (p == swsn_pkg::OPQ_PW'(swsn_pkg::OPQ_DEPTH - 1)) begin
			return '0;
		end
		return p + swsn_pkg::OPQ_PW'(1);
	endfunction

	assign full    = fill_q == swsn_pkg::OPQ_CW'(swsn_pkg::OPQ_DEPTH);
	assign valid   = fill_q != '0;
	assign head_op = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + swsn_pkg::OPQ_CW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - swsn_pkg::OPQ_CW'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

// File: rtl/swsn_back.sv
// Back end: descriptor memory, window register and the command sequencer
// that appends, retires, rescans and emits frames. Depends on swsn_pkg.
module swsn_back #(
	parameter int QUEUE_DEPTH = swsn_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [swsn_pkg::WIN_W-1:0]  cfg_wdata,
	input  logic                        q_valid,
	input  swsn_pkg::op_t               q_op,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output swsn_pkg::out_beat_t         out_beat
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int EW    = (CNT_W > swsn_pkg::WIN_W) ? CNT_W : swsn_pkg::WIN_W;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SEND     = 3'd1;
	localparam logic [2:0] ST_POP_RD   = 3'd2;
	localparam logic [2:0] ST_POP_CMP  = 3'd3;
	localparam logic [2:0] ST_SCAN_RD  = 3'd4;
	localparam logic [2:0] ST_SCAN_CHK = 3'd5;
	localparam logic [2:0] ST_FLUSH    = 3'd6;

	logic [2:0]                    state_q;
	logic [swsn_pkg::WIN_W-1:0]    win_q;
	logic [IDX_W-1:0]              head_q;
	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              popped_q;
	logic [EW-1:0]                 pos_q;
	logic [EW-1:0]                 lim_q;
	logic [swsn_pkg::NAK_W-1:0]    nak_n_q;
	swsn_pkg::op_t                 op_q;
	swsn_pkg::desc_t               held_q;
	logic                          held_v_q;
	swsn_pkg::out_beat_t           out_q;
	logic                          out_v_q;
	swsn_pkg::desc_t               mem [QUEUE_DEPTH];
	swsn_pkg::desc_t               rd_q;

	logic [swsn_pkg::WIN_W-1:0]    w_use;
	logic [EW-1:0]                 w_e;
	logic [EW-1:0]                 cnt_e;
	logic [EW-1:0]                 pop_e;
	logic [EW-1:0]                 min_cw;
	logic [EW-1:0]                 ack_start;
	logic [IDX_W-1:0]              slot_pos;
	logic [IDX_W-1:0]              slot_wr;
	logic [IDX_W-1:0]              rd_addr;
	logic                          send_ok;
	logic                          send_tx;
	logic                          nak_mode;
	logic                          is_match;
	logic                          scan_end;
	logic                          ack_pop;
	logic                          out_free;
	logic                          emit_ok;
	logic                          emit_en;
	logic                          flush_en;
	logic                          push_en;
	swsn_pkg::desc_t               emit_desc;
	swsn_pkg::desc_t               send_desc;
	swsn_pkg::out_beat_t           push_beat;

	// ring slot of a queue position, both operands below the depth
	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
		input logic [IDX_W-1:0] off);
		logic [IDX_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
			sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	// window saturated to 1..max
	always_comb begin
		if (win_q == '0) begin
			w_use = swsn_pkg::WIN_W'(1);
		end else if (win_q > swsn_pkg::WIN_W'(swsn_pkg::WINDOW_MAX)) begin
			w_use = swsn_pkg::WIN_W'(swsn_pkg::WINDOW_MAX);
		end else begin
			w_use = win_q;
		end
	end

	assign w_e       = EW'(w_use);
	assign cnt_e     = EW'(count_q);
	assign pop_e     = EW'(popped_q);
	assign min_cw    = (cnt_e < w_e) ? cnt_e : w_e;
	assign ack_start = (pop_e >= w_e) ? '0 : (w_e - pop_e);

	assign slot_pos = slot_of(head_q, pos_q[IDX_W-1:0]);
	assign slot_wr  = slot_of(head_q, count_q[IDX_W-1:0]);
	assign rd_addr  = (state_q == ST_POP_RD) ? head_q : slot_pos;

	assign send_ok  = count_q < CNT_W'(QUEUE_DEPTH);
	assign send_tx  = (cnt_e + EW'(1)) <= w_e;
	assign nak_mode = op_q.cmd == swsn_pkg::CMD_NAK;
	assign is_match = !nak_mode || (rd_q.seq == op_q.key);
	assign scan_end = (pos_q >= lim_q) ||
		(nak_mode && nak_n_q == swsn_pkg::NAK_W'(swsn_pkg::NAK_MAX));
	assign ack_pop  = rd_q.seq <= op_q.key;

	assign out_free = !out_v_q || !out_stall;
	assign emit_ok  = !held_v_q || out_free;

	assign send_desc.seq = op_q.key;
	assign send_desc.tag = op_q.tag;
	assign send_desc.len = op_q.len;

	// emit and flush decisions; an emitted frame waits in the held register
	// until the next one or the end of the command decides its last flag
	always_comb begin
		q_pop     = 1'b0;
		emit_en   = 1'b0;
		flush_en  = 1'b0;
		emit_desc = rd_q;
		unique case (state_q)
			ST_IDLE: begin
				q_pop = q_valid;
			end
			ST_SEND: begin
				emit_en   = send_ok && send_tx;
				emit_desc = send_desc;
			end
			ST_SCAN_CHK: begin
				emit_en = is_match && emit_ok;
			end
			ST_FLUSH: begin
				flush_en = held_v_q && out_free;
			end
			default: begin
			end
		endcase
	end

	assign push_en               = (emit_en && held_v_q) || flush_en;
	assign push_beat.tx_tag      = held_q.tag;
	assign push_beat.tx_sequence = held_q.seq;
	assign push_beat.tx_length   = held_q.len;
	assign push_beat.last_of_run = flush_en;

	// window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= swsn_pkg::WIN_W'(swsn_pkg::WINDOW_RESET);
		end else if (cfg_wen) begin
			win_q <= cfg_wdata;
		end
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			popped_q <= '0;
			pos_q    <= '0;
			lim_q    <= '0;
			nak_n_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						unique case (q_op.cmd)
							swsn_pkg::CMD_SEND: begin
								state_q <= ST_SEND;
							end
							swsn_pkg::CMD_ACK: begin
								popped_q <= '0;
								state_q  <= ST_POP_RD;
							end
							swsn_pkg::CMD_NAK: begin
								pos_q   <= '0;
								lim_q   <= cnt_e;
								nak_n_q <= '0;
								state_q <= ST_SCAN_RD;
							end
							swsn_pkg::CMD_TIMEOUT: begin
								pos_q   <= '0;
								lim_q   <= min_cw;
								state_q <= ST_SCAN_RD;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SEND: begin
					if (send_ok) begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= ST_FLUSH;
				end
				ST_POP_RD: begin
					if (count_q == '0) begin
						if (popped_q == '0) begin
							state_q <= ST_FLUSH;
						end else begin
							pos_q   <= ack_start;
							lim_q   <= min_cw;
							state_q <= ST_SCAN_RD;
						end
					end else begin
						state_q <= ST_POP_CMP;
					end
				end
				ST_POP_CMP: begin
					if (ack_pop) begin
						head_q   <= (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 :
							head_q + IDX_W'(1);
						count_q  <= count_q - CNT_W'(1);
						popped_q <= popped_q + CNT_W'(1);
						state_q  <= ST_POP_RD;
					end else if (popped_q == '0) begin
						state_q <= ST_FLUSH;
					end else begin
						pos_q   <= ack_start;
						lim_q   <= min_cw;
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SCAN_RD: begin
					state_q <= scan_end ? ST_FLUSH : ST_SCAN_CHK;
				end
				ST_SCAN_CHK: begin
					if (!is_match) begin
						pos_q   <= pos_q + EW'(1);
						state_q <= ST_SCAN_RD;
					end else if (emit_ok) begin
						pos_q <= pos_q + EW'(1);
						if (nak_mode) begin
							nak_n_q <= nak_n_q + swsn_pkg::NAK_W'(1);
						end
						state_q <= ST_SCAN_RD;
					end
				end
				ST_FLUSH: begin
					if (!held_v_q || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command in progress
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			op_q <= q_op;
		end
	end

	// held frame valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q <= 1'b0;
		end else if (emit_en) begin
			held_v_q <= 1'b1;
		end else if (flush_en) begin
			held_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			held_q <= emit_desc;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push_en) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			out_q <= push_beat;
		end
	end

	assign out_valid = out_v_q;
	assign out_beat  = out_q;

	// descriptor memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_SEND && send_ok) begin
			mem[slot_wr] <= send_desc;
		end
		rd_q <= mem[rd_addr];
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("descriptor count beyond queue depth");

	a_idle_no_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !held_v_q)
		else $error("held frame left over at end of command");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_stall) |-> !push_en)
		else $error("output beat overwritten while stalled");

	a_count_changes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_POP_CMP && state_q != ST_SEND) |=>
		count_q == $past(count_q))
		else $error("descriptor count changed outside send or ack");

	a_nak_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nak_n_q <= swsn_pkg::NAK_W'(swsn_pkg::NAK_MAX))
		else $error("too many nak resends");

endmodule

// File: rtl/sliding_window_sender_nak_resend.sv
// Sliding window sender with resend on nak: a queue of frame descriptors (sequence,
// buffer tag, length) driven by send, ack, nak and timeout commands; each command gives
// zero or more transmit beats, the final one flagged last_of_run. Commands are taken by
// a front stage into a two-entry command queue, so the input keeps flowing while the
// back end works, until that queue is full. The back end reads the descriptor memory
// through one registered read port, with a read state and then a compare or check state
// for each descriptor it inspects; each frame beat also waits while out_stall is high.
// The window register holds 4 after reset and is saturated to 1..8 in use.
// Depends on swsn_pkg, swsn_front, swsn_opq and swsn_back.
module sliding_window_sender_nak_resend #(
	parameter int QUEUE_DEPTH = swsn_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  swsn_pkg::in_beat_t          in_beat,
	output logic                        out_valid,
	input  logic                        out_stall,
	output swsn_pkg::out_beat_t         out_beat,
	input  logic                        cfg_wen,
	input  logic [swsn_pkg::WIN_W-1:0]  cfg_wdata
);

	logic          f_valid;
	swsn_pkg::op_t f_op;
	logic          q_full;
	logic          q_valid;
	swsn_pkg::op_t q_op;
	logic          q_pop;

	// accept and classify
	swsn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_beat  (in_beat),
		.op_valid (f_valid),
		.op       (f_op),
		.op_full  (q_full)
	);

	// command queue
	swsn_opq u_opq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (f_valid),
		.push_op (f_op),
		.full    (q_full),
		.valid   (q_valid),
		.head_op (q_op),
		.pop     (q_pop)
	);

	// execute against the descriptor queue
	swsn_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_op      (q_op),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat)
	);

endmodule

// File: test/tb_sliding_window_sender_nak_resend.sv
`timescale 1ns / 100ps
// Testbench for the sliding window sender: a directed table, then shaped random commands.
// Every transmit beat is checked against a table beat or an in-bench model of the descriptor queue.
// Depends on swsn_pkg and sliding_window_sender_nak_resend.
module tb_sliding_window_sender_nak_resend;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int SETTLE_CYCLES   = 256;
	localparam int RAND_PHASES     = 8;
	localparam int ITEMS_PER_PHASE = 40;
	localparam int DIR_ROWS        = 24;

	typedef enum logic [1:0] {ROW_ITEM, ROW_WINDOW} row_kind_t;
	typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_ONE} row_exp_t;

	// one line of the directed table; ROW_WINDOW rows only use win
	typedef struct {
		row_kind_t           kind;
		logic [1:0]          cmd;
		logic [31:0]         seq;
		logic [31:0]         ackn;
		logic [15:0]         tag;
		logic [6:0]          len;
		int                  reps;
		logic [31:0]         seq_step;
		logic [3:0]          win;
		row_exp_t            exp_kind;
		swsn_pkg::out_beat_t exp_beat;
	} dir_row_t;

	localparam swsn_pkg::out_beat_t NO_BEAT = '0;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	swsn_pkg::in_beat_t            in_beat = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	swsn_pkg::out_beat_t           out_beat;
	logic                          cfg_wen = 1'b0;
	logic [swsn_pkg::WIN_W-1:0]    cfg_wdata = '0;

	// model state
	swsn_pkg::desc_t               frame_queue[$];
	logic [3:0]                    window_reg;
	swsn_pkg::out_beat_t           tx_run[$];
	swsn_pkg::out_beat_t           pending_tx[$];
	logic [31:0]                   next_seq;

	// idling control
	int                            burst_left = 0;
	bit                            gaps_on = 1'b1;
	logic [15:0]                   stall_mask = '0;
	int unsigned                   cycle_count = 0;
	int                            errors = 0;

	dir_row_t                      dir_rows [DIR_ROWS];

	sliding_window_sender_nak_resend DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_beat   (in_beat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// window register as used: saturated to 1..8
	function automatic int unsigned window_used();
		int unsigned w;
		w = window_reg;
		if (w < 1) w = 1;
		if (w > swsn_pkg::WINDOW_MAX) w = swsn_pkg::WINDOW_MAX;
		return w;
	endfunction

	function automatic swsn_pkg::out_beat_t beat_of(input swsn_pkg::desc_t d);
		swsn_pkg::out_beat_t o;
		o.tx_tag      = d.tag;
		o.tx_sequence = d.seq;
		o.tx_length   = d.len;
		o.last_of_run = 1'b0;
		return o;
	endfunction

	// works out the frames one command transmits, in order, into tx_run
	task automatic compute_tx_run(input swsn_pkg::in_beat_t b);
		int unsigned w;
		int unsigned popped;
		int unsigned first;
		int unsigned stop;
		swsn_pkg::desc_t d;
		w = window_used();
		tx_run.delete();
		case (b.command)
			swsn_pkg::CMD_SEND: begin
				if (frame_queue.size() < swsn_pkg::QUEUE_DEPTH) begin
					d.seq = b.frame_sequence;
					d.tag = b.frame_tag;
					d.len = b.frame_length;
					frame_queue = {frame_queue, d};
					if (frame_queue.size() <= w) tx_run = {tx_run, beat_of(d)};
				end
			end
			swsn_pkg::CMD_ACK: begin
				popped = 0;
				while (frame_queue.size() > 0 && frame_queue[0].seq <= b.ack_number) begin
					frame_queue.delete(0);
					popped++;
				end
				if (popped > 0) begin
					first = (popped >= w) ? 0 : w - popped;
					stop  = (frame_queue.size() < w) ? frame_queue.size() : w;
					for (int unsigned i = first; i < stop; i++)
						tx_run = {tx_run, beat_of(frame_queue[i])};
				end
			end
			swsn_pkg::CMD_NAK: begin
				for (int i = 0; i < frame_queue.size() && tx_run.size() < swsn_pkg::NAK_MAX;
						i++)
					if (frame_queue[i].seq == b.ack_number)
						tx_run = {tx_run, beat_of(frame_queue[i])};
			end
			default: begin
				stop = (frame_queue.size() < w) ? frame_queue.size() : w;
				for (int unsigned i = 0; i < stop; i++)
					tx_run = {tx_run, beat_of(frame_queue[i])};
			end
		endcase
		if (tx_run.size() > 0) tx_run[tx_run.size() - 1].last_of_run = 1'b1;
	endtask

	// present one command beat, with a burst gap first when a burst has run out
	task automatic offer_beat(input swsn_pkg::in_beat_t b, input row_exp_t exp_kind,
			input swsn_pkg::out_beat_t exp_beat);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (gaps_on) gap = $urandom_range(1, 6);
		end
		burst_left--;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_beat  <= b;
		do @(posedge clk); while (in_stall);
		compute_tx_run(b);
		case (exp_kind)
			EXP_NONE: ;
			EXP_ONE:  pending_tx = {pending_tx, exp_beat};
			default:  pending_tx = {pending_tx, tx_run};
		endcase
	endtask

	// block idle: nothing outstanding, then room for commands that give no beat
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_tx.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [3:0] v);
		settle();
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen    <= 1'b0;
		window_reg  = v;
	endtask

	// mostly well-formed traffic around the queued sequences, some pure noise
	function automatic swsn_pkg::in_beat_t random_command();
		swsn_pkg::in_beat_t b;
		int unsigned pick;
		int unsigned n;
		b.command        = 2'($urandom_range(0, 3));
		b.frame_sequence = $urandom();
		b.ack_number     = $urandom();
		b.frame_tag      = 16'($urandom_range(0, 65535));
		b.frame_length   = 7'($urandom_range(0, 112));
		pick = $urandom_range(0, 99);
		n    = frame_queue.size();
		if (pick < 10) return b;
		if (pick < 55) begin
			b.command        = swsn_pkg::CMD_SEND;
			b.frame_sequence = next_seq;
			if ($urandom_range(0, 7) != 0) next_seq = next_seq + $urandom_range(1, 3);
		end else if (pick < 80) begin
			b.command = swsn_pkg::CMD_ACK;
			if (n > 0) begin
				case ($urandom_range(0, 3))
					0:       b.ack_number = frame_queue[0].seq - 32'd1;
					1:       b.ack_number = frame_queue[n - 1].seq;
					default: b.ack_number = frame_queue[$urandom_range(0, n - 1)].seq;
				endcase
			end
		end else if (pick < 94) begin
			b.command = swsn_pkg::CMD_NAK;
			if (n > 0 && $urandom_range(0, 4) != 0)
				b.ack_number = frame_queue[$urandom_range(0, n - 1)].seq;
		end else begin
			b.command = swsn_pkg::CMD_TIMEOUT;
		end
		return b;
	endfunction

	// output check and receiver stall pattern
	always @(posedge clk) begin : tx_check
		swsn_pkg::out_beat_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_tx.size() == 0) begin
				errors = errors + 1;
				$display("%0t: tx beat with none expected: got tag %h seq %h len %0d last %b",
					$time, out_beat.tx_tag, out_beat.tx_sequence, out_beat.tx_length,
					out_beat.last_of_run);
			end else begin
				e = pending_tx[0];
				pending_tx.delete(0);
				if (out_beat.tx_tag !== e.tx_tag || out_beat.tx_sequence !== e.tx_sequence ||
						out_beat.tx_length !== e.tx_length ||
						out_beat.last_of_run !== e.last_of_run) begin
					errors = errors + 1;
					$display("%0t: tx beat mismatch: expected tag %h seq %h len %0d last %b",
						$time, e.tx_tag, e.tx_sequence, e.tx_length, e.last_of_run);
					$display("%0t:                       got tag %h seq %h len %0d last %b",
						$time, out_beat.tx_tag, out_beat.tx_sequence, out_beat.tx_length,
						out_beat.last_of_run);
				end
			end
		end
		out_stall <= stall_mask[cycle_count[3:0]];
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		swsn_pkg::in_beat_t b;
		logic [3:0] win;
		// kind, cmd, seq, ackn, tag, len, reps, step, win, expectation, expected beat
		dir_rows = '{
			// empty queue after reset: nothing to pop, resend or time out
			'{ROW_ITEM, swsn_pkg::CMD_ACK, 0, 0, 0, 0, 1, 0, 0, EXP_NONE, NO_BEAT},
			'{ROW_ITEM, swsn_pkg::CMD_NAK, 0, 0, 0, 0, 1, 0, 0, EXP_NONE, NO_BEAT},
			'{ROW_ITEM, swsn_pkg::CMD_TIMEOUT, 0, 0, 0, 0, 1, 0, 0, EXP_NONE, NO_BEAT},
			// window of 4 after reset: four sends go out, the fifth waits
			'{ROW_ITEM, swsn_pkg::CMD_SEND, 10, 0, 16'h0000, 0, 1, 0, 0, EXP_ONE,
				{16'h0000, 32'd10, 7'd0, 1'b1}},
			'{ROW_ITEM, swsn_pkg::CMD_SEND, 32'hFFFFFFFF, 0, 16'hFFFF, 112, 1, 0, 0, EXP_ONE,
				{16'hFFFF, 32'hFFFFFFFF, 7'd112, 1'b1}},
			'{ROW_ITEM, swsn_pkg::CMD_SEND, 5, 32'hFFFFFFFF, 16'h1234, 7, 1, 0, 0, EXP_ONE,
				{16'h1234, 32'd5, 7'd7, 1'b1}},
			'{ROW_ITEM, swsn_pkg::CMD_SEND, 20, 0, 16'h00FF, 64, 1, 0, 0, EXP_ONE,
				{16'h00FF, 32'd20, 7'd64, 1'b1}},
			'{ROW_ITEM, swsn_pkg::CMD_SEND, 30, 0, 16'hFF00, 1, 1, 0, 0, EXP_NONE, NO_BEAT},
			'{ROW_ITEM, swsn_pkg::CMD_NAK, 0, 5, 0, 0, 1, 0, 0, EXP_MODEL, NO_BEAT},
			'{ROW_ITEM, swsn_pkg::CMD_NAK, 0, 77, 0, 0, 1, 0, 0, EXP_NONE, NO_BEAT},
			'{ROW_ITEM, swsn_pkg::CMD_TIMEOUT, 0, 0, 0, 0, 1, 0, 0, EXP_MODEL, NO_BEAT},
			// head not covered, then one retired so the waiting frame enters
			'{ROW_ITEM, swsn_pkg::CMD_ACK, 0, 9, 0, 0, 1, 0, 0, EXP_NONE, NO_BEAT},
			'{ROW_ITEM, swsn_pkg::CMD_ACK, 0, 10, 0, 0, 1, 0, 0, EXP_MODEL, NO_BEAT},
			'{ROW_ITEM, swsn_pkg::CMD_ACK, 0, 32'hFFFFFFFF, 0, 0, 1, 0, 0, EXP_MODEL, NO_BEAT},
			// window 1, fill to full plus one dropped send, all one sequence
			'{ROW_WINDOW, swsn_pkg::CMD_SEND, 0, 0, 0, 0, 0, 0, 4'd1, EXP_MODEL, NO_BEAT},
			'{ROW_ITEM, swsn_pkg::CMD_SEND, 100, 0, 16'h4000, 3, 17, 0, 0, EXP_MODEL, NO_BEAT},
			// nak matching every entry, capped
			'{ROW_ITEM, swsn_pkg::CMD_NAK, 0, 100, 0, 0, 1, 0, 0, EXP_MODEL, NO_BEAT},
			'{ROW_ITEM, swsn_pkg::CMD_ACK, 0, 99, 0, 0, 1, 0, 0, EXP_NONE, NO_BEAT},
			// out of range windows saturate
			'{ROW_WINDOW, swsn_pkg::CMD_SEND, 0, 0, 0, 0, 0, 0, 4'd15, EXP_MODEL, NO_BEAT},
			'{ROW_ITEM, swsn_pkg::CMD_TIMEOUT, 0, 0, 0, 0, 1, 0, 0, EXP_MODEL, NO_BEAT},
			'{ROW_WINDOW, swsn_pkg::CMD_SEND, 0, 0, 0, 0, 0, 0, 4'd0, EXP_MODEL, NO_BEAT},
			'{ROW_ITEM, swsn_pkg::CMD_TIMEOUT, 0, 0, 0, 0, 1, 0, 0, EXP_MODEL, NO_BEAT},
			'{ROW_WINDOW, swsn_pkg::CMD_SEND, 0, 0, 0, 0, 0, 0, 4'd9, EXP_MODEL, NO_BEAT},
			'{ROW_ITEM, swsn_pkg::CMD_ACK, 0, 100, 0, 0, 1, 0, 0, EXP_MODEL, NO_BEAT}
		};

		frame_queue.delete();
		window_reg = 4'(swsn_pkg::WINDOW_RESET);
		next_seq   = $urandom() & 32'h0FFFFFFF;
		stall_mask = 16'($urandom() & 32'h0000FFFE);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_WINDOW) begin
				write_window(dir_rows[r].win);
			end else begin
				for (int k = 0; k < dir_rows[r].reps; k++) begin
					b.command        = dir_rows[r].cmd;
					b.frame_sequence = dir_rows[r].seq + 32'(k) * dir_rows[r].seq_step;
					b.ack_number     = dir_rows[r].ackn;
					b.frame_tag      = dir_rows[r].tag + 16'(k);
					b.frame_length   = 7'((int'(dir_rows[r].len) + k * 7) % 113);
					offer_beat(b, dir_rows[r].exp_kind, dir_rows[r].exp_beat);
				end
			end
		end

		// random phases, each with its own window, sender gaps and stall pattern
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0:       win = 4'd8;
				1:       win = 4'd1;
				2:       win = 4'd15;
				3:       win = 4'd0;
				4:       win = 4'd9;
				default: win = 4'($urandom_range(0, 15));
			endcase
			write_window(win);
			gaps_on    = (p % 3 != 0);
			stall_mask = (p % 4 == 0) ? 16'h0000 : 16'($urandom() & 32'h0000FFFE);
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				offer_beat(random_command(), EXP_MODEL, NO_BEAT);
		end

		settle();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
